/* rtl/jpeg_huffman_table_decoder_core_assert.svh */
// Assertion helpers for the Huffman decoder core.
`ifndef JPEG_HUFFMAN_TABLE_DECODER_CORE_ASSERT_SVH
`define JPEG_HUFFMAN_TABLE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JHTD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define JHTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/jhtd_pkg.sv */
package jhtd_pkg;

	localparam int NUM_LENGTHS         = 16;
	localparam int LV_W                = 4;
	localparam int CODE_W              = 16;
	localparam int RUN_W               = 17;
	localparam int COUNT_W             = 8;
	localparam int SYM_W               = 8;
	localparam int LEN_W               = 5;
	localparam int OFF_W               = 9;
	localparam int FUNC_W              = 2;
	localparam int DEF_MAX_CODE_LENGTH = 16;
	localparam int DEF_MAX_SYMBOLS     = 256;

	localparam logic [FUNC_W-1:0] FUNC_TABLE_BYTE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CODE_BIT   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART    = 2'd2;

	// Per-length table entry as seen by the code matcher
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [CODE_W-1:0]  first;
		logic [OFF_W-1:0]   offset;
		logic [OFF_W-1:0]   total;
		logic [OFF_W-1:0]   loaded;
	} tbl_lookup_t;

	// Completed code waiting for its symbol read
	typedef struct packed {
		logic             valid;
		logic             hit;
		logic [LEN_W-1:0] length;
	} match_s1_t;

endpackage

/* rtl/jhtd_in_if.sv */
interface jhtd_in_if;
	logic                       valid;
	logic                       ready;
	logic [jhtd_pkg::FUNC_W-1:0] func;
	logic [jhtd_pkg::SYM_W-1:0]  table_byte;
	logic                       code_bit;

	modport source(output valid, output func, output table_byte, output code_bit, input ready);
	modport sink(input valid, input func, input table_byte, input code_bit, output ready);
endinterface

/* rtl/jhtd_out_if.sv */
interface jhtd_out_if;
	logic                       valid;
	logic                       ready;
	logic [jhtd_pkg::SYM_W-1:0]  symbol;
	logic [jhtd_pkg::LEN_W-1:0]  code_length;
	logic                       invalid_code;

	modport source(output valid, output symbol, output code_length, output invalid_code,
		input ready);
	modport sink(input valid, input symbol, input code_length, input invalid_code,
		output ready);
endinterface

/* rtl/jhtd_symbol_mem.sv */
module jhtd_symbol_mem #(
	parameter int DEPTH = jhtd_pkg::DEF_MAX_SYMBOLS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              wa,
	input  logic [jhtd_pkg::SYM_W-1:0] wd,
	input  logic                       re,
	input  logic [AW-1:0]              ra,
	output logic [jhtd_pkg::SYM_W-1:0] rd
);
	import jhtd_pkg::*;

	logic [SYM_W-1:0] mem [DEPTH];
	logic [SYM_W-1:0] rd_q;
	logic [AW-1:0]    addr;

	// single port: a write and a read never fall in the same cycle
	assign addr = we ? wa : ra;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wd;
		end
		if (re) begin
			rd_q <= mem[addr];
		end
	end

	assign rd = rd_q;
endmodule

/* rtl/jhtd_table.sv */
module jhtd_table #(
	parameter int MAX_SYMBOLS = jhtd_pkg::DEF_MAX_SYMBOLS,
	parameter int AW          = $clog2(MAX_SYMBOLS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load_en,
	input  logic                          restart_en,
	input  logic [jhtd_pkg::SYM_W-1:0]    byte_in,
	input  logic [jhtd_pkg::LV_W-1:0]     lv,
	output jhtd_pkg::tbl_lookup_t         lookup,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_wa,
	output logic [jhtd_pkg::SYM_W-1:0]    mem_wd
);
	import jhtd_pkg::*;

	localparam int POS_W = $clog2(NUM_LENGTHS + 1);

	logic [COUNT_W-1:0] count_q  [NUM_LENGTHS];
	logic [CODE_W-1:0]  first_q  [NUM_LENGTHS];
	logic [OFF_W-1:0]   offset_q [NUM_LENGTHS];
	logic [POS_W-1:0]   count_pos_q;
	logic [RUN_W-1:0]   run_q;
	logic [OFF_W-1:0]   cum_q;
	logic [OFF_W-1:0]   sym_count_q;

	logic               built;
	logic               count_load;
	logic               sym_load;
	logic [RUN_W:0]     run_sum;
	logic [RUN_W+1:0]   run_shift;
	logic [RUN_W-1:0]   run_next;
	logic [OFF_W:0]     cum_sum;
	logic [OFF_W-1:0]   cum_next;
	logic [CODE_W-1:0]  first_now;
	logic [LV_W-1:0]    pos_idx;

	assign built      = count_pos_q == POS_W'(NUM_LENGTHS);
	assign count_load = load_en && !built;
	assign sym_load   = load_en && built && (sym_count_q < cum_q);
	assign pos_idx    = LV_W'(count_pos_q);

	// canonical build, one length per count byte
	assign run_sum   = {1'b0, run_q} + (RUN_W + 1)'(byte_in);
	assign run_shift = {run_sum, 1'b0};
	assign run_next  = (run_shift > (RUN_W + 2)'({RUN_W{1'b1}})) ? {RUN_W{1'b1}}
		: run_shift[RUN_W-1:0];
	assign cum_sum   = {1'b0, cum_q} + (OFF_W + 1)'(byte_in);
	assign cum_next  = (cum_sum > (OFF_W + 1)'(MAX_SYMBOLS)) ? OFF_W'(MAX_SYMBOLS)
		: cum_sum[OFF_W-1:0];
	assign first_now = (run_q > RUN_W'({CODE_W{1'b1}})) ? {CODE_W{1'b1}}
		: run_q[CODE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_pos_q <= '0;
			run_q       <= '0;
			cum_q       <= '0;
			sym_count_q <= '0;
			for (int i = 0; i < NUM_LENGTHS; i++) begin
				count_q[i] <= '0;
			end
		end else if (restart_en) begin
			count_pos_q <= '0;
			run_q       <= '0;
			cum_q       <= '0;
			sym_count_q <= '0;
			for (int i = 0; i < NUM_LENGTHS; i++) begin
				count_q[i] <= '0;
			end
		end else if (count_load) begin
			count_q[pos_idx] <= byte_in;
			count_pos_q      <= count_pos_q + POS_W'(1);
			run_q            <= run_next;
			cum_q            <= cum_next;
		end else if (sym_load) begin
			sym_count_q <= sym_count_q + OFF_W'(1);
		end
	end

	// only read once the sixteenth count is in
	always_ff @(posedge clk) begin
		if (count_load) begin
			first_q[pos_idx]  <= first_now;
			offset_q[pos_idx] <= cum_q;
		end
	end

	assign mem_we = sym_load;
	assign mem_wa = AW'(sym_count_q);
	assign mem_wd = byte_in;

	always_comb begin
		lookup.count  = count_q[lv];
		lookup.first  = built ? first_q[lv] : '0;
		lookup.offset = built ? offset_q[lv] : '0;
		lookup.total  = built ? cum_q : '0;
		lookup.loaded = sym_count_q;
	end
endmodule

/* rtl/jhtd_code_match.sv */
module jhtd_code_match #(
	parameter int MAX_CODE_LENGTH = jhtd_pkg::DEF_MAX_CODE_LENGTH,
	parameter int MAX_SYMBOLS     = jhtd_pkg::DEF_MAX_SYMBOLS,
	parameter int AW              = $clog2(MAX_SYMBOLS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      bit_en,
	input  logic                      restart_en,
	input  logic                      drain,
	input  logic                      code_bit,
	input  jhtd_pkg::tbl_lookup_t     lookup,
	output logic [jhtd_pkg::LV_W-1:0] lv,
	output logic                      mem_re,
	output logic [AW-1:0]             mem_ra,
	output jhtd_pkg::match_s1_t       s1
);
	import jhtd_pkg::*;

	localparam int PL_W  = $clog2(MAX_CODE_LENGTH + 1);
	localparam int IDX_W = CODE_W + 1;

	logic [CODE_W-1:0] partial_q;
	logic [PL_W-1:0]   plen_q;
	match_s1_t         match_s1;

	logic [CODE_W-1:0] code_next;
	logic [PL_W-1:0]   len_next;
	logic [CODE_W-1:0] diff;
	logic              match;
	logic              done;
	logic [IDX_W-1:0]  idx;
	logic              hit;

	assign lv        = LV_W'(plen_q);
	assign code_next = {partial_q[CODE_W-2:0], code_bit};
	assign len_next  = plen_q + PL_W'(1);
	assign diff      = code_next - lookup.first;
	assign match     = (code_next >= lookup.first) && (diff < CODE_W'(lookup.count));
	assign done      = match || (len_next == PL_W'(MAX_CODE_LENGTH));
	assign idx       = IDX_W'(lookup.offset) + IDX_W'(diff);
	assign hit       = match && (idx < IDX_W'(lookup.total)) && (idx < IDX_W'(lookup.loaded));

	assign mem_re = bit_en && hit;
	assign mem_ra = idx[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			plen_q    <= '0;
			match_s1  <= '0;
		end else begin
			if (restart_en || (bit_en && done)) begin
				partial_q <= '0;
				plen_q    <= '0;
			end else if (bit_en) begin
				partial_q <= code_next;
				plen_q    <= len_next;
			end
			if (bit_en && done) begin
				match_s1.valid  <= 1'b1;
				match_s1.hit    <= hit;
				match_s1.length <= LEN_W'(len_next);
			end else if (drain) begin
				match_s1.valid <= 1'b0;
			end
		end
	end

	assign s1 = match_s1;
endmodule

/* rtl/jpeg_huffman_table_decoder_core.sv */
// Channel  | Modport | Word fields                        | Handshake
// item     | sink    | func, table_byte, code_bit         | valid/ready
// result   | source  | symbol, code_length, invalid_code  | valid/ready
//
// One word per cycle on item while result drains; a code bit that completes a code
// reaches result through the symbol memory read, then the output register.
// The symbol store is one single-port memory with a registered read.
// Reset (arst_n low) clears the length table, load counters and partial code at once.
// A stall on result holds the output register and the pending lookup; item then stalls while one is pending.
`include "jpeg_huffman_table_decoder_core_assert.svh"

module jpeg_huffman_table_decoder_core #(
	parameter int MAX_CODE_LENGTH = jhtd_pkg::DEF_MAX_CODE_LENGTH,
	parameter int MAX_SYMBOLS     = jhtd_pkg::DEF_MAX_SYMBOLS
) (
	input  logic              clk,
	input  logic              arst_n,
	jhtd_in_if.sink           item,
	jhtd_out_if.source        result
);
	import jhtd_pkg::*;

	localparam int AW = $clog2(MAX_SYMBOLS);

	// handshake and decode of the incoming word
	logic              accept;
	logic              adv;
	logic              load_en;
	logic              bit_en;
	logic              restart_en;

	// table and memory wiring
	tbl_lookup_t       lookup;
	logic [LV_W-1:0]   lv;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [SYM_W-1:0]  mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;
	logic [SYM_W-1:0]  mem_rd;
	match_s1_t         s1;

	// output register
	logic              out_valid_q;
	logic [SYM_W-1:0]  out_symbol_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_invalid_q;

	// advance the pending lookup when the output register is free or being taken
	assign adv        = !out_valid_q || result.ready;
	assign item.ready = !s1.valid || adv;
	assign accept     = item.valid && item.ready;
	assign load_en    = accept && (item.func == FUNC_TABLE_BYTE);
	assign bit_en     = accept && (item.func == FUNC_CODE_BIT);
	// unused func code falls through: drop the word, no result
	assign restart_en = accept && (item.func == FUNC_RESTART);

	jhtd_table #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.AW          (AW)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_en    (load_en),
		.restart_en (restart_en),
		.byte_in    (item.table_byte),
		.lv         (lv),
		.lookup     (lookup),
		.mem_we     (mem_we),
		.mem_wa     (mem_wa),
		.mem_wd     (mem_wd)
	);

	jhtd_code_match #(
		.MAX_CODE_LENGTH (MAX_CODE_LENGTH),
		.MAX_SYMBOLS     (MAX_SYMBOLS),
		.AW              (AW)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.bit_en     (bit_en),
		.restart_en (restart_en),
		.drain      (adv),
		.code_bit   (item.code_bit),
		.lookup     (lookup),
		.lv         (lv),
		.mem_re     (mem_re),
		.mem_ra     (mem_ra),
		.s1         (s1)
	);

	jhtd_symbol_mem #(
		.DEPTH (MAX_SYMBOLS),
		.AW    (AW)
	) u_mem (
		.clk (clk),
		.we  (mem_we),
		.wa  (mem_wa),
		.wd  (mem_wd),
		.re  (mem_re),
		.ra  (mem_ra),
		.rd  (mem_rd)
	);

	// output valid: load from the pending lookup, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1.valid && adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload: a miss reports symbol zero
	always_ff @(posedge clk) begin
		if (s1.valid && adv) begin
			out_symbol_q  <= s1.hit ? mem_rd : '0;
			out_len_q     <= s1.length;
			out_invalid_q <= !s1.hit;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.symbol       = out_symbol_q;
	assign result.code_length  = out_len_q;
	assign result.invalid_code = out_invalid_q;

	`JHTD_ASSERT_NEXT(a_s1_held_on_stall, clk, arst_n, s1.valid && !adv, s1.valid)
	`JHTD_ASSERT_NEXT(a_s1_moves_out, clk, arst_n, s1.valid && adv, out_valid_q)
	`JHTD_ASSERT_IMPL(a_invalid_has_zero, clk, arst_n, out_valid_q && out_invalid_q, out_symbol_q == '0)
	`JHTD_ASSERT_IMPL(a_len_in_range, clk, arst_n, out_valid_q, (out_len_q != '0) && (out_len_q <= LEN_W'(MAX_CODE_LENGTH)))
endmodule
